@@ design/packed_simd_alu_64_macros.svh @@
// Assertion macros used by the checker file.
`ifndef PACKED_SIMD_ALU_64_MACROS_SVH
`define PACKED_SIMD_ALU_64_MACROS_SVH

// Next-cycle implication, suspended while reset is low.
`define PSA64_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define PSA64_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/psa64_pkg.sv @@
`timescale 1ns / 1ps

package psa64_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned LaneW  = 8;
  localparam int unsigned NLanes = WordW / LaneW;
  localparam int unsigned LaneIdxW = $clog2(NLanes);

  localparam logic [3:0] OP_ADD8  = 4'd0;
  localparam logic [3:0] OP_ADD16 = 4'd1;
  localparam logic [3:0] OP_ADD32 = 4'd2;
  localparam logic [3:0] OP_ADD64 = 4'd3;
  localparam logic [3:0] OP_SUB8  = 4'd4;
  localparam logic [3:0] OP_SUB16 = 4'd5;
  localparam logic [3:0] OP_SUB32 = 4'd6;
  localparam logic [3:0] OP_SUB64 = 4'd7;
  localparam logic [3:0] OP_AND   = 4'd8;
  localparam logic [3:0] OP_OR    = 4'd9;
  localparam logic [3:0] OP_XOR   = 4'd10;
  localparam logic [3:0] OP_ANDC  = 4'd11;
  localparam logic [3:0] OP_ORC   = 4'd12;

  typedef enum logic [2:0] {
    LOP_ADD,
    LOP_SUB,
    LOP_AND,
    LOP_OR,
    LOP_XOR,
    LOP_ANDC,
    LOP_ORC,
    LOP_ZERO
  } lane_op_t;

  // Control broadcast from the decoder to every lane slice.
  typedef struct packed {
    lane_op_t op;
    logic     sub;
  } lane_ctrl_t;

endpackage

@@ design/psa64_lane.sv @@
`timescale 1ns / 1ps

module psa64_lane (
  input  psa64_pkg::lane_ctrl_t            ctrl,
  input  logic [psa64_pkg::LaneW-1:0]      a,
  input  logic [psa64_pkg::LaneW-1:0]      b,
  input  logic                             cin,
  output logic [psa64_pkg::LaneW-1:0]      res,
  output logic                             cout
);

  logic [psa64_pkg::LaneW-1:0] b_eff;
  logic [psa64_pkg::LaneW:0]   sum;

  // Subtract as a + ~b + 1, the one coming in on the carry at a lane start.
  assign b_eff = ctrl.sub ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + {{psa64_pkg::LaneW{1'b0}}, cin};
  assign cout  = sum[psa64_pkg::LaneW];

  always_comb begin
    case (ctrl.op)
      psa64_pkg::LOP_ADD,
      psa64_pkg::LOP_SUB:  res = sum[psa64_pkg::LaneW-1:0];
      psa64_pkg::LOP_AND:  res = a & b;
      psa64_pkg::LOP_OR:   res = a | b;
      psa64_pkg::LOP_XOR:  res = a ^ b;
      psa64_pkg::LOP_ANDC: res = a & ~b;
      psa64_pkg::LOP_ORC:  res = a | ~b;
      default:             res = '0;
    endcase
  end

endmodule

@@ design/packed_simd_alu_64.sv @@
// Results are registered; a transfer taken at a clock edge shows on out_* right after
// that edge and is taken by the receiver at the next edge.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// Eight 8-bit lane slices work in parallel; the carry chain between them is
// cut at lane starts chosen by the opcode's lane size, then results register.
// Reset (rst_n low, synchronous) clears out_valid; the result word is not reset.
`timescale 1ns / 1ps

module packed_simd_alu_64 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [3:0]                     in_opcode,
  input  logic [psa64_pkg::WordW-1:0]    in_operand_a,
  input  logic [psa64_pkg::WordW-1:0]    in_operand_b,
  output logic                           out_valid,
  output logic [psa64_pkg::WordW-1:0]    out_result_word
);

  psa64_pkg::lane_ctrl_t               ctrl;
  logic [1:0]                          size_sel;
  logic [psa64_pkg::LaneIdxW-1:0]      grp_mask;
  logic [psa64_pkg::NLanes:0]          carry;
  logic [psa64_pkg::NLanes-1:0]        lane_cin;
  logic [psa64_pkg::WordW-1:0]         lane_res;
  logic                                accept;

  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic [psa64_pkg::WordW-1:0]         out_result_word_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    ctrl.sub = 1'b0;
    case (in_opcode) inside
      [psa64_pkg::OP_ADD8:psa64_pkg::OP_ADD64]: ctrl.op = psa64_pkg::LOP_ADD;
      [psa64_pkg::OP_SUB8:psa64_pkg::OP_SUB64]: begin
        ctrl.op  = psa64_pkg::LOP_SUB;
        ctrl.sub = 1'b1;
      end
      psa64_pkg::OP_AND:  ctrl.op = psa64_pkg::LOP_AND;
      psa64_pkg::OP_OR:   ctrl.op = psa64_pkg::LOP_OR;
      psa64_pkg::OP_XOR:  ctrl.op = psa64_pkg::LOP_XOR;
      psa64_pkg::OP_ANDC: ctrl.op = psa64_pkg::LOP_ANDC;
      psa64_pkg::OP_ORC:  ctrl.op = psa64_pkg::LOP_ORC;
      default:            ctrl.op = psa64_pkg::LOP_ZERO;
    endcase
  end

  // Lane size 8 << size_sel; a slice starts a lane when its low index bits are zero.
  assign size_sel = in_opcode[1:0];
  assign grp_mask = ({{(psa64_pkg::LaneIdxW-1){1'b0}}, 1'b1} << size_sel)
                    - {{(psa64_pkg::LaneIdxW-1){1'b0}}, 1'b1};

  assign carry[0] = 1'b0;

  for (genvar i = 0; i < psa64_pkg::NLanes; i++) begin : g_lane
    localparam logic [psa64_pkg::LaneIdxW-1:0] Idx = psa64_pkg::LaneIdxW'(i);

    // Cut the chain at a lane start, injecting the subtract's plus one.
    assign lane_cin[i] = ((Idx & grp_mask) == '0) ? ctrl.sub : carry[i];

    psa64_lane u_lane (
      .ctrl (ctrl),
      .a    (in_operand_a[i*psa64_pkg::LaneW +: psa64_pkg::LaneW]),
      .b    (in_operand_b[i*psa64_pkg::LaneW +: psa64_pkg::LaneW]),
      .cin  (lane_cin[i]),
      .res  (lane_res[i*psa64_pkg::LaneW +: psa64_pkg::LaneW]),
      .cout (carry[i+1])
    );
  end

  assign out_valid_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Merge the lane slices into the output word; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_result_word_r <= lane_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = out_result_word_r;

endmodule

@@ design/psa64_checker.sv @@
`timescale 1ns / 1ps
`include "packed_simd_alu_64_macros.svh"

module psa64_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [3:0]                     in_opcode,
  input logic [psa64_pkg::WordW-1:0]    in_operand_a,
  input logic [psa64_pkg::WordW-1:0]    in_operand_b,
  input logic                           out_valid,
  input logic [psa64_pkg::WordW-1:0]    out_result_word
);

  logic                        xfer;
  logic                        xor_xfer;
  logic                        unused_xfer;
  logic [psa64_pkg::WordW-1:0] xor_word;

  assign xfer        = start && !busy;
  assign xor_xfer    = xfer && (in_opcode == psa64_pkg::OP_XOR);
  assign unused_xfer = xfer && (in_opcode > psa64_pkg::OP_ORC);
  assign xor_word    = in_operand_a ^ in_operand_b;

  `PSA64_ASSERT_ALWAYS(a_rst_quiet, !rst_n, !out_valid, "result strobe after reset")
  `PSA64_ASSERT_NEXT(a_one_result, xfer, out_valid, "accepted item gave no result")
  `PSA64_ASSERT_NEXT(a_no_phantom, !xfer, !out_valid, "result without transfer")
  `PSA64_ASSERT_NEXT(a_xor_word, xor_xfer, out_result_word == $past(xor_word), "xor result wrong")
  `PSA64_ASSERT_NEXT(a_unused_zero, unused_xfer, out_result_word == '0, "unused opcode not zero")

endmodule

bind packed_simd_alu_64 psa64_checker u_psa64_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_opcode       (in_opcode),
  .in_operand_a    (in_operand_a),
  .in_operand_b    (in_operand_b),
  .out_valid       (out_valid),
  .out_result_word (out_result_word)
);
